[hdl/acull_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and register indexes for the box frustum cull pipeline.
package acull_pkg;

    localparam int NUM_PLANES = 6;
    localparam int AXES       = 3;
    localparam int IN_W       = 16;   // center, signed Q11.4
    localparam int HALF_W     = 15;   // half extent, unsigned Q11.4
    localparam int COORD_W    = 18;   // corner coordinate, signed
    localparam int COEF_W     = 16;   // plane word
    localparam int PROD_W     = COEF_W + COORD_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int D_SHIFT    = 14;   // aligns Q11.4 offset with Q1.14 * Q11.4
    localparam int PLANE_W    = 4 * COEF_W;
    localparam int CFG_IDX_W  = 3;
    localparam int PIPE_D     = 4;    // register stages from request to result

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_NEAR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_FAR    = 3'd5;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COEF_W-1:0]  t_coef;

    typedef struct packed {
        t_coef d;
        t_coef nz;
        t_coef ny;
        t_coef nx;
    } t_plane;

    // Box corners: minimum and maximum per axis (index 0 = x)
    typedef struct packed {
        t_coord [AXES-1:0] lo;
        t_coord [AXES-1:0] hi;
    } t_box;

endpackage

[hdl/acull_corner.sv]
`timescale 1ns / 1ps
// Stage 1: box extents from center and half size, registered.
module acull_corner
    import acull_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [IN_W-1:0]   i_center_x,
    input  logic signed [IN_W-1:0]   i_center_y,
    input  logic signed [IN_W-1:0]   i_center_z,
    input  logic        [HALF_W-1:0] i_half_x,
    input  logic        [HALF_W-1:0] i_half_y,
    input  logic        [HALF_W-1:0] i_half_z,
    output t_box                     o_box
);

    logic signed [IN_W-1:0]   w_c [AXES];
    logic        [HALF_W-1:0] w_h [AXES];
    t_box                     n_box;
    t_box                     r_box;

    assign w_c[0] = i_center_x;
    assign w_c[1] = i_center_y;
    assign w_c[2] = i_center_z;
    assign w_h[0] = i_half_x;
    assign w_h[1] = i_half_y;
    assign w_h[2] = i_half_z;

    // Full width, so no wrap: 16-bit signed +/- 15-bit unsigned fits 18 bits
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_box.lo[a] = COORD_W'(w_c[a]) - COORD_W'(w_h[a]);
            n_box.hi[a] = COORD_W'(w_c[a]) + COORD_W'(w_h[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_box <= n_box;
    end

    assign o_box = r_box;

endmodule

[hdl/acull_plane.sv]
`timescale 1ns / 1ps
// Stages 2 and 3: p-vertex dot product against one plane and sign test.
module acull_plane
    import acull_pkg::*;
(
    input  logic   i_clk,
    input  t_box   i_box,
    input  t_plane i_plane,
    output logic   o_pass
);

    t_coef                     w_n [AXES];
    t_coord                    w_p [AXES];
    logic signed [PROD_W-1:0]  n_prod [AXES];
    logic signed [PROD_W-1:0]  r_prod [AXES];
    logic signed [SUM_W-1:0]   w_sum;
    logic                      r_pass;

    assign w_n[0] = i_plane.nx;
    assign w_n[1] = i_plane.ny;
    assign w_n[2] = i_plane.nz;

    // Only the corner furthest along the normal matters: if it is behind,
    // all eight are. Non-negative normal component picks the max extent.
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            w_p[a]    = w_n[a][COEF_W-1] ? i_box.lo[a] : i_box.hi[a];
            n_prod[a] = w_n[a] * w_p[a];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign w_sum = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]) + SUM_W'(r_prod[2])
                 + (SUM_W'(i_plane.d) <<< D_SHIFT);

    // Zero counts as in front
    always_ff @(posedge i_clk) begin
        r_pass <= ~w_sum[SUM_W-1];
    end

    assign o_pass = r_pass;

endmodule

[hdl/aabb_frustum_cull_test.sv]
`timescale 1ns / 1ps
// Top level: axis-aligned box versus six-plane view frustum cull test.
//
// Usage
//   Request channel: drive the box center (signed Q11.4) and half extents
//   (unsigned Q11.4) with i_start high; a request is taken at every rising
//   edge with i_start high and o_busy low. o_busy is always low, so one box
//   can be issued every cycle.
//   Result channel: o_valid strobes for one cycle with o_visible. Results
//   leave in request order. There is no back-pressure; the receiver must
//   take every strobe.
//   Throughput: one box per cycle. A request passes the register stages
//   in order: extents, products, plane sum and sign, plane AND.
//   Configuration: six 64-bit plane registers written through i_cfg_we,
//   i_cfg_idx and i_cfg_data, taken at once. Indexes above five are dropped.
//   Planes are read live by the pipeline, so write them only while no
//   request is in flight.
//   Reset (synchronous, active low) clears the plane registers and the valid
//   pipeline. All-zero planes always pass, so every box is visible after
//   reset.
module aabb_frustum_cull_test
    import acull_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic signed [IN_W-1:0]   i_center_x,
    input  logic signed [IN_W-1:0]   i_center_y,
    input  logic signed [IN_W-1:0]   i_center_z,
    input  logic        [HALF_W-1:0] i_half_x,
    input  logic        [HALF_W-1:0] i_half_y,
    input  logic        [HALF_W-1:0] i_half_z,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [PLANE_W-1:0]       i_cfg_data,
    output logic                     o_valid,
    output logic                     o_visible
);

    t_plane                r_plane [NUM_PLANES];
    logic [PIPE_D-1:0]     r_valid;
    logic [PIPE_D-1:0]     n_valid;
    logic                  w_accept;
    t_box                  w_box;
    logic [NUM_PLANES-1:0] w_pass;
    logic                  r_visible;

    // Fully pipelined: never busy
    assign o_busy   = 1'b0;
    assign w_accept = i_start & ~o_busy;

    // Valid bits ride alongside the payload stages
    assign n_valid = {r_valid[PIPE_D-2:0], w_accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '{default: '0};
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PLANE_LEFT:   r_plane[0] <= i_cfg_data;
                    CFG_PLANE_RIGHT:  r_plane[1] <= i_cfg_data;
                    CFG_PLANE_BOTTOM: r_plane[2] <= i_cfg_data;
                    CFG_PLANE_TOP:    r_plane[3] <= i_cfg_data;
                    CFG_PLANE_NEAR:   r_plane[4] <= i_cfg_data;
                    CFG_PLANE_FAR:    r_plane[5] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Stage 1: box extents
    acull_corner u_corner (
        .i_clk      (i_clk),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_center_z (i_center_z),
        .i_half_x   (i_half_x),
        .i_half_y   (i_half_y),
        .i_half_z   (i_half_z),
        .o_box      (w_box)
    );

    // Stages 2 and 3: one dot-product lane per plane
    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
        acull_plane u_plane (
            .i_clk   (i_clk),
            .i_box   (w_box),
            .i_plane (r_plane[p]),
            .o_pass  (w_pass[p])
        );
    end

    // Stage 4: culled if any plane has the whole box behind it
    always_ff @(posedge i_clk) begin
        r_visible <= &w_pass;
    end

    assign o_valid   = r_valid[PIPE_D-1];
    assign o_visible = r_visible;

    // A result strobe always traces back to an earlier request on i_start
    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, PIPE_D))
        else $error("result strobe without matching request");

    // Reset leaves no result in flight
    a_reset_flushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_valid && !r_valid[0])
        else $error("result strobe straight after reset");

    // Visible only when every plane lane passed in the previous stage
    a_visible_all_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_visible |-> $past(&w_pass))
        else $error("box reported visible with a failing plane");

    // Culled only when some lane failed
    a_culled_one_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_visible |-> $past(w_pass != {NUM_PLANES{1'b1}}))
        else $error("box reported culled with all planes passing");

endmodule
